// ----- sv/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and constants for the JSON string unescaper
// Beat payload structs, result kinds, error codes and the hex digit decode.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Input beat payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    // Result beat payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
        logic       last_of_run;
    } out_item_t;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OPEN      = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_NO_LOW    = 3'd4;
    localparam logic [2:0] ERR_LOW_RANGE = 3'd5;
    localparam logic [2:0] ERR_UNTERM    = 3'd6;

    // Character codes
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // Code point limits
    localparam logic [15:0] CP_MAX_1BYTE = 16'h007f;
    localparam logic [15:0] CP_MAX_2BYTE = 16'h07ff;
    localparam logic [15:0] CP_HI_FIRST  = 16'hd800;
    localparam logic [15:0] CP_LO_FIRST  = 16'hdc00;
    localparam logic [15:0] CP_LO_LAST   = 16'hdfff;
    localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

    // UTF-8 lead and continuation marks
    localparam logic [7:0] UTF_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF_LEAD3 = 8'he0;
    localparam logic [7:0] UTF_LEAD4 = 8'hf0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [5:0] UTF_MASK  = 6'h3f;

    // Hex digit decode: bit 4 set means the byte is a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

// ----- sv/json_string_unescape.sv -----
// Results: the first result of an input beat is offered in the cycle after it is taken.
// Throughput: one input beat per cycle while each beat yields at most one result
// and out_ready is held high; a beat that yields several results (up to four) holds
// the input until all but its last result are taken. A beat with no result holds nothing.
// Reset: rst_n clears the decoder to expect an opening quote and empties the
// result buffer.
// ----------------------------------------------------------------------------
// json_string_unescape - streaming JSON quoted-string decoder
// Decodes one byte per beat, expanding escapes and \u sequences to UTF-8.
// ----------------------------------------------------------------------------
module json_string_unescape
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jsu_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jsu_pkg::out_item_t out_data
);
    import jsu_pkg::*;

    typedef enum logic [9:0] {
        PH_OPEN   = 10'b0000000001,
        PH_BODY   = 10'b0000000010,
        PH_ESC    = 10'b0000000100,
        PH_CR     = 10'b0000001000,
        PH_HEX1   = 10'b0000010000,
        PH_SURBS  = 10'b0000100000,
        PH_SURU   = 10'b0001000000,
        PH_HEX2   = 10'b0010000000,
        PH_CLOSED = 10'b0100000000,
        PH_ERR    = 10'b1000000000
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] error_code;
    } res_t;

    // Decoder state
    phase_t      phase_reg, phase_next;
    logic        single_reg, single_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  digits_reg, digits_next;
    logic [9:0]  hs_reg, hs_next;

    // Result buffer
    res_t        res_reg [4];
    res_t        res_next [4];
    logic [2:0]  rem_reg;
    logic [1:0]  pos_reg;
    logic [2:0]  n_res;

    logic        in_fire;
    logic        out_fire;

    // Combinational decode helpers
    logic [7:0]  c;
    logic [7:0]  quote;
    logic [4:0]  hd;
    logic [15:0] v;
    logic [20:0] cp;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && out_ready);

    assign c     = in_data.in_byte;
    assign quote = single_reg ? CH_SQUOTE : CH_DQUOTE;
    assign hd    = hex_digit(c);
    assign v     = {acc_reg[11:0], hd[3:0]};
    assign cp    = {1'b0, hs_reg, v[9:0]} + CP_SUPP_BASE;

    // One beat of decoding: next state and up to four results
    always_comb
    begin
        phase_next  = phase_reg;
        single_next = single_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        hs_next     = hs_reg;
        n_res       = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            res_next[i] = '{out_byte: 8'd0, kind: KIND_BYTE, error_code: ERR_NONE};
        end

        if (in_data.end_of_input)
        begin
            unique case (phase_reg)
                PH_OPEN:
                begin
                    res_next[0] = '{8'd0, KIND_ERROR, ERR_OPEN};
                    n_res       = 3'd1;
                end
                PH_BODY, PH_ESC, PH_CR, PH_HEX1, PH_SURBS, PH_SURU, PH_HEX2:
                begin
                    res_next[0] = '{8'd0, KIND_ERROR, ERR_UNTERM};
                    n_res       = 3'd1;
                end
                default:
                begin
                end
            endcase
            phase_next  = PH_OPEN;
            digits_next = 2'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_OPEN, PH_CLOSED:
                begin
                    if (c == CH_DQUOTE || c == CH_SQUOTE)
                    begin
                        single_next = (c == CH_SQUOTE);
                        phase_next  = PH_BODY;
                    end
                    else
                    begin
                        res_next[0] = '{8'd0, KIND_ERROR, ERR_OPEN};
                        n_res       = 3'd1;
                        phase_next  = PH_ERR;
                    end
                end
                PH_BODY, PH_CR:
                begin
                    if (phase_reg == PH_CR && c == CH_LF)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (c == quote)
                    begin
                        res_next[0] = '{8'd0, KIND_CLOSED, ERR_NONE};
                        n_res       = 3'd1;
                        phase_next  = PH_CLOSED;
                    end
                    else
                    begin
                        res_next[0] = '{c, KIND_BYTE, ERR_NONE};
                        n_res       = 3'd1;
                        phase_next  = PH_BODY;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_BODY;
                    n_res      = 3'd1;
                    case (c)
                        CH_LOW_B: res_next[0] = '{8'h08, KIND_BYTE, ERR_NONE};
                        CH_LOW_F: res_next[0] = '{8'h0c, KIND_BYTE, ERR_NONE};
                        CH_LOW_N: res_next[0] = '{8'h0a, KIND_BYTE, ERR_NONE};
                        CH_LOW_R: res_next[0] = '{8'h0d, KIND_BYTE, ERR_NONE};
                        CH_LOW_T: res_next[0] = '{8'h09, KIND_BYTE, ERR_NONE};
                        CH_BSLASH, CH_SLASH, CH_DQUOTE, CH_SQUOTE:
                            res_next[0] = '{c, KIND_BYTE, ERR_NONE};
                        CH_LF:
                        begin
                            n_res = 3'd0;
                        end
                        CH_CR:
                        begin
                            n_res      = 3'd0;
                            phase_next = PH_CR;
                        end
                        CH_LOW_U:
                        begin
                            n_res       = 3'd0;
                            acc_next    = 16'd0;
                            digits_next = 2'd0;
                            phase_next  = PH_HEX1;
                        end
                        default:
                        begin
                            res_next[0] = '{8'd0, KIND_ERROR, ERR_ESCAPE};
                            phase_next  = PH_ERR;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!hd[4])
                    begin
                        res_next[0] = '{8'd0, KIND_ERROR, ERR_HEX};
                        n_res       = 3'd1;
                        phase_next  = PH_ERR;
                    end
                    else
                    begin
                        acc_next = v;
                        if (digits_reg != 2'd3)
                        begin
                            digits_next = digits_reg + 2'd1;
                        end
                        else
                        begin
                            digits_next = 2'd0;
                            if (phase_reg == PH_HEX1)
                            begin
                                // First code unit complete
                                phase_next = PH_BODY;
                                if (v <= CP_MAX_1BYTE)
                                begin
                                    res_next[0] = '{v[7:0], KIND_BYTE, ERR_NONE};
                                    n_res       = 3'd1;
                                end
                                else if (v <= CP_MAX_2BYTE)
                                begin
                                    res_next[0] = '{UTF_LEAD2 | {3'd0, v[10:6]},
                                                    KIND_BYTE, ERR_NONE};
                                    res_next[1] = '{UTF_CONT | {2'd0, v[5:0]},
                                                    KIND_BYTE, ERR_NONE};
                                    n_res       = 3'd2;
                                end
                                else if (v < CP_HI_FIRST || v >= CP_LO_FIRST)
                                begin
                                    res_next[0] = '{UTF_LEAD3 | {4'd0, v[15:12]},
                                                    KIND_BYTE, ERR_NONE};
                                    res_next[1] = '{UTF_CONT | {2'd0, v[11:6]},
                                                    KIND_BYTE, ERR_NONE};
                                    res_next[2] = '{UTF_CONT | {2'd0, v[5:0]},
                                                    KIND_BYTE, ERR_NONE};
                                    n_res       = 3'd3;
                                end
                                else
                                begin
                                    // High surrogate: wait for the low half
                                    hs_next    = v[9:0];
                                    phase_next = PH_SURBS;
                                end
                            end
                            else if (v < CP_LO_FIRST || v > CP_LO_LAST)
                            begin
                                res_next[0] = '{8'd0, KIND_ERROR, ERR_LOW_RANGE};
                                n_res       = 3'd1;
                                phase_next  = PH_ERR;
                            end
                            else
                            begin
                                // Surrogate pair complete: four-byte sequence
                                phase_next  = PH_BODY;
                                res_next[0] = '{UTF_LEAD4 | {5'd0, cp[20:18]},
                                                KIND_BYTE, ERR_NONE};
                                res_next[1] = '{UTF_CONT | {2'd0, cp[17:12] & UTF_MASK},
                                                KIND_BYTE, ERR_NONE};
                                res_next[2] = '{UTF_CONT | {2'd0, cp[11:6]},
                                                KIND_BYTE, ERR_NONE};
                                res_next[3] = '{UTF_CONT | {2'd0, cp[5:0]},
                                                KIND_BYTE, ERR_NONE};
                                n_res       = 3'd4;
                            end
                        end
                    end
                end
                PH_SURBS:
                begin
                    if (c == CH_BSLASH)
                    begin
                        phase_next = PH_SURU;
                    end
                    else
                    begin
                        res_next[0] = '{8'd0, KIND_ERROR, ERR_NO_LOW};
                        n_res       = 3'd1;
                        phase_next  = PH_ERR;
                    end
                end
                PH_SURU:
                begin
                    if (c == CH_LOW_U)
                    begin
                        acc_next    = 16'd0;
                        digits_next = 2'd0;
                        phase_next  = PH_HEX2;
                    end
                    else
                    begin
                        res_next[0] = '{8'd0, KIND_ERROR, ERR_NO_LOW};
                        n_res       = 3'd1;
                        phase_next  = PH_ERR;
                    end
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end
    end

    // Decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPEN;
            single_reg <= 1'b0;
            acc_reg    <= 16'd0;
            digits_reg <= 2'd0;
            hs_reg     <= 10'd0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            single_reg <= single_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            hs_reg     <= hs_next;
        end
    end

    // Result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 3'd0;
            pos_reg <= 2'd0;
        end
        else if (in_fire)
        begin
            rem_reg <= n_res;
            pos_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            rem_reg <= rem_reg - 3'd1;
            pos_reg <= pos_reg + 2'd1;
        end
    end

    // Result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    // Output beat
    assign out_valid            = (rem_reg != 3'd0);
    assign out_data.out_byte    = res_reg[pos_reg].out_byte;
    assign out_data.kind        = res_reg[pos_reg].kind;
    assign out_data.error_code  = res_reg[pos_reg].error_code;
    assign out_data.last_of_run = (rem_reg == 3'd1);

endmodule
